FILE: src/slhse_pkg.sv
// slhse_pkg: shared types, constants and helpers for the syslog header strip/escape block.
// No dependencies; slhse_header, slhse_escape and the top level refer to it by scoped names.
package slhse_pkg;

    // Header window: the first bytes of a message are held here until parsed
    localparam int WINDOW_DEPTH = 20;
    localparam int FILL_W       = $clog2(WINDOW_DEPTH + 1);

    // Output length limit
    localparam int CFG_W            = 11;
    localparam int LINE_BUFFER_SIZE = 1280;
    localparam int LIMIT_CAP_INT    = (LINE_BUFFER_SIZE - 1 < 2**CFG_W - 1) ?
                                      LINE_BUFFER_SIZE - 1 : 2**CFG_W - 1;
    localparam logic [CFG_W-1:0] LIMIT_CAP       = CFG_W'(LIMIT_CAP_INT);
    localparam logic [CFG_W-1:0] MAX_CHARS_RESET = 11'd1279;

    localparam logic signed [7:0] LEVEL_DEFAULT = 8'sd6;

    // Characters
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_DEL    = 8'h7F;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic [7:0]        char0;
        logic [7:0]        char1;
        logic [7:0]        char2;
        logic [7:0]        char3;
        logic [2:0]        char_count;
        logic signed [7:0] priority_level;
        logic              end_of_message;
        logic              was_truncated;
    } t_out_word;

    typedef struct packed {
        logic [CFG_W-1:0] max_output_chars;
    } t_cfg_word;

    // One step for the escaper: push a body byte, or close the message
    typedef struct packed {
        logic              finish;
        logic              step_final;
        logic [7:0]        data;
        logic signed [7:0] level;
    } t_event;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

FILE: src/slhse_chan_if.sv
// slhse_chan_if: valid/ready channel carrying one word of a payload type.
// Depends on nothing; payload types come from slhse_pkg at instantiation.
interface slhse_chan_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: src/slhse_header.sv
// slhse_header: collects the message header, parses priority and timestamp,
// and feeds body bytes to the escaper as events. Depends on slhse_pkg, slhse_chan_if.
module slhse_header (
    input  logic                i_clk,
    input  logic                i_rst_n,
    slhse_chan_if.sink          i_in,
    output logic                o_ev_valid,
    input  logic                i_ev_ready,
    output slhse_pkg::t_event   o_ev
);

    localparam logic [2:0] PH_COLLECT = 3'd0;
    localparam logic [2:0] PH_RESOLVE = 3'd1;
    localparam logic [2:0] PH_FLUSH   = 3'd2;
    localparam logic [2:0] PH_BODY    = 3'd3;
    localparam logic [2:0] PH_LASTFIN = 3'd4;

    localparam int FW = slhse_pkg::FILL_W;

    function automatic logic in_rng(input logic [7:0] c, input logic [7:0] lo,
                                    input logic [7:0] hi);
        return (c >= lo) && (c <= hi);
    endfunction

    // "Mmm dD HH:MM:SS " in a 16-byte slice of the window
    function automatic logic ts_match(input logic [15:0][7:0] t);
        return in_rng(t[0], "A", "Z") && in_rng(t[1], "a", "z") && in_rng(t[2], "a", "z")
            && (t[3] == slhse_pkg::CH_SPACE)
            && ((t[4] == slhse_pkg::CH_SPACE) || in_rng(t[4], "1", "3"))
            && slhse_pkg::is_digit(t[5]) && (t[6] == slhse_pkg::CH_SPACE)
            && in_rng(t[7], "0", "2") && slhse_pkg::is_digit(t[8])
            && (t[9] == slhse_pkg::CH_COLON)
            && in_rng(t[10], "0", "5") && slhse_pkg::is_digit(t[11])
            && (t[12] == slhse_pkg::CH_COLON)
            && in_rng(t[13], "0", "5") && slhse_pkg::is_digit(t[14])
            && (t[15] == slhse_pkg::CH_SPACE);
    endfunction

    logic [7:0]        r_window [slhse_pkg::WINDOW_DEPTH];
    logic [FW-1:0]     r_fill, n_fill;
    logic [FW-1:0]     r_rd_idx, n_rd_idx;
    logic [2:0]        r_phase, n_phase;
    logic              r_final, n_final;
    logic signed [7:0] r_level, n_level;
    logic              r_ev_valid, n_ev_valid;
    slhse_pkg::t_event r_ev, n_ev;

    logic              ev_adv;
    logic              in_ready;
    logic              in_acc;
    logic              last_rd;

    // header parse
    logic              dig1, min1, dig2;
    logic [7:0]        tens, two_dig, neg_dig;
    logic signed [7:0] pri_level;
    logic [FW-1:0]     pri_len;
    logic [FW-1:0]     body_start;
    logic [15:0][7:0]  ts0, ts3, ts4;
    logic              ok0, ok3, ok4, ts_hit;

    always_comb begin
        for (int j = 0; j < 16; j++) begin
            ts0[j] = r_window[j];
            ts3[j] = r_window[j + 3];
            ts4[j] = r_window[j + 4];
        end
    end

    always_comb begin
        dig1    = slhse_pkg::is_digit(r_window[1]);
        min1    = (r_window[1] == slhse_pkg::CH_MINUS);
        dig2    = slhse_pkg::is_digit(r_window[2]);
        tens    = {4'b0, r_window[1][3:0]};
        two_dig = (tens << 3) + (tens << 1) + {4'b0, r_window[2][3:0]};
        neg_dig = 8'd0 - {4'b0, r_window[2][3:0]};

        pri_level = slhse_pkg::LEVEL_DEFAULT;
        pri_len   = '0;
        if ((r_fill >= FW'(4)) && (r_window[0] == slhse_pkg::CH_LT) && (dig1 || min1)) begin
            pri_level = dig1 ? $signed(tens) : -8'sd1;
            if (dig2) begin
                pri_level = min1 ? $signed(neg_dig) : $signed(two_dig);
                if (r_window[3] == slhse_pkg::CH_GT) begin
                    pri_len = FW'(4);
                end
            end else if (r_window[2] == slhse_pkg::CH_GT) begin
                pri_len = FW'(3);
            end
        end

        // the timestamp only counts if the whole 16 bytes were received
        ok0 = 1'b0;
        ok3 = 1'b0;
        ok4 = 1'b0;
        if (r_fill >= FW'(16)) begin
            ok0 = ts_match(ts0);
        end
        if (r_fill >= FW'(19)) begin
            ok3 = ts_match(ts3);
        end
        if (r_fill == FW'(slhse_pkg::WINDOW_DEPTH)) begin
            ok4 = ts_match(ts4);
        end

        if (pri_len == FW'(4)) begin
            ts_hit = ok4;
        end else if (pri_len == FW'(3)) begin
            ts_hit = ok3;
        end else begin
            ts_hit = ok0;
        end
        body_start = ts_hit ? pri_len + FW'(16) : pri_len;
    end

    assign ev_adv  = !r_ev_valid || i_ev_ready;
    assign last_rd = (r_rd_idx + FW'(1) == r_fill);
    assign in_acc  = i_in.valid && in_ready;

    always_comb begin
        n_fill     = r_fill;
        n_rd_idx   = r_rd_idx;
        n_phase    = r_phase;
        n_final    = r_final;
        n_level    = r_level;
        n_ev_valid = r_ev_valid && !i_ev_ready;
        n_ev       = r_ev;
        in_ready   = 1'b0;

        unique case (r_phase)
            PH_COLLECT: begin
                in_ready = 1'b1;
                if (i_in.valid) begin
                    n_fill  = r_fill + FW'(1);
                    n_final = i_in.payload.last_byte;
                    if (i_in.payload.last_byte ||
                        (r_fill == FW'(slhse_pkg::WINDOW_DEPTH - 1))) begin
                        n_phase = PH_RESOLVE;
                    end
                end
            end
            PH_RESOLVE: begin
                n_level  = pri_level;
                n_rd_idx = body_start;
                if ((body_start == r_fill) && !r_final) begin
                    n_phase = PH_BODY;
                end else begin
                    n_phase = PH_FLUSH;
                end
            end
            PH_FLUSH: begin
                if (ev_adv) begin
                    n_ev_valid = 1'b1;
                    if (r_rd_idx != r_fill) begin
                        // a short message ends in this pass: every replayed
                        // byte belongs to its final step
                        n_ev.finish     = 1'b0;
                        n_ev.step_final = r_final;
                        n_ev.data       = r_window[r_rd_idx];
                        n_ev.level      = r_level;
                        n_rd_idx        = r_rd_idx + FW'(1);
                        if (last_rd && !r_final) begin
                            n_phase = PH_BODY;
                        end
                    end else begin
                        n_ev.finish     = 1'b1;
                        n_ev.step_final = 1'b1;
                        n_ev.data       = '0;
                        n_ev.level      = r_level;
                        n_phase         = PH_COLLECT;
                        n_fill          = '0;
                        n_level         = slhse_pkg::LEVEL_DEFAULT;
                    end
                end
            end
            PH_BODY: begin
                in_ready = ev_adv;
                if (i_in.valid && ev_adv) begin
                    n_ev_valid      = 1'b1;
                    n_ev.finish     = 1'b0;
                    n_ev.step_final = i_in.payload.last_byte;
                    n_ev.data       = i_in.payload.data_byte;
                    n_ev.level      = r_level;
                    if (i_in.payload.last_byte) begin
                        n_phase = PH_LASTFIN;
                    end
                end
            end
            PH_LASTFIN: begin
                if (ev_adv) begin
                    n_ev_valid      = 1'b1;
                    n_ev.finish     = 1'b1;
                    n_ev.step_final = 1'b1;
                    n_ev.data       = '0;
                    n_ev.level      = r_level;
                    n_phase         = PH_COLLECT;
                    n_fill          = '0;
                    n_level         = slhse_pkg::LEVEL_DEFAULT;
                end
            end
            default: begin
                n_phase = PH_COLLECT;
            end
        endcase
    end

    assign i_in.ready = in_ready;
    assign o_ev_valid = r_ev_valid;
    assign o_ev       = r_ev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= '0;
            r_rd_idx   <= '0;
            r_phase    <= PH_COLLECT;
            r_final    <= 1'b0;
            r_level    <= slhse_pkg::LEVEL_DEFAULT;
            r_ev_valid <= 1'b0;
        end else begin
            r_fill     <= n_fill;
            r_rd_idx   <= n_rd_idx;
            r_phase    <= n_phase;
            r_final    <= n_final;
            r_level    <= n_level;
            r_ev_valid <= n_ev_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ev <= n_ev;
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && (r_phase == PH_COLLECT)) begin
            r_window[r_fill] <= i_in.payload.data_byte;
        end
    end

    a_collect_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_COLLECT |-> r_fill < FW'(slhse_pkg::WINDOW_DEPTH))
        else $error("header window overfilled while collecting");

    a_flush_end_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_FLUSH && r_rd_idx == r_fill) |-> r_final)
        else $error("flush drained without end of message");

    a_accept_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |-> (r_phase == PH_COLLECT || r_phase == PH_BODY))
        else $error("input word taken outside collect or body phase");

endmodule

FILE: src/slhse_escape.sv
// slhse_escape: escapes each body byte against its successor, applies the length
// limit and registers at most one result word per byte. Depends on slhse_pkg, slhse_chan_if.
module slhse_escape (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_ev_valid,
    output logic                           o_ev_ready,
    input  slhse_pkg::t_event              i_ev,
    input  logic [slhse_pkg::CFG_W-1:0]    i_limit,
    slhse_chan_if.source                   o_out
);

    localparam int CW = slhse_pkg::CFG_W;

    logic [7:0]           r_held, n_held;
    logic                 r_held_v, n_held_v;
    logic [CW-1:0]        r_count, n_count;
    logic                 r_cut, n_cut;
    logic                 r_done, n_done;
    logic                 r_out_valid, n_out_valid;
    slhse_pkg::t_out_word r_out, n_out;

    logic                 ev_acc;
    logic                 next_dig;
    logic [3:0][7:0]      esc;
    logic [2:0]           k;
    logic                 do_emit;
    logic [CW:0]          sum;
    logic                 room;
    logic [CW-1:0]        rem;
    logic [2:0]           m;
    logic                 res_made;
    logic                 cut_after;
    logic [3:0][7:0]      ch;

    assign o_ev_ready = !r_out_valid || o_out.ready;
    assign ev_acc     = i_ev_valid && o_ev_ready;

    // escape of the held byte, looking at the byte that follows it
    always_comb begin
        next_dig = !i_ev.finish && slhse_pkg::is_digit(i_ev.data);
        esc      = '0;
        if (r_held == slhse_pkg::CH_BSLASH) begin
            esc[0] = slhse_pkg::CH_BSLASH;
            esc[1] = slhse_pkg::CH_BSLASH;
            k      = 3'd2;
        end else if ((r_held >= slhse_pkg::CH_DEL) || ((r_held < 8'd32) && next_dig)) begin
            esc[0] = slhse_pkg::CH_BSLASH;
            esc[1] = slhse_pkg::CH_ZERO + {6'b0, r_held[7:6]};
            esc[2] = slhse_pkg::CH_ZERO + {5'b0, r_held[5:3]};
            esc[3] = slhse_pkg::CH_ZERO + {5'b0, r_held[2:0]};
            k      = 3'd4;
        end else if (r_held < 8'd8) begin
            esc[0] = slhse_pkg::CH_BSLASH;
            esc[1] = slhse_pkg::CH_ZERO + {5'b0, r_held[2:0]};
            k      = 3'd2;
        end else if (r_held < 8'd32) begin
            esc[0] = slhse_pkg::CH_BSLASH;
            esc[1] = slhse_pkg::CH_ZERO + {6'b0, r_held[4:3]};
            esc[2] = slhse_pkg::CH_ZERO + {5'b0, r_held[2:0]};
            k      = 3'd3;
        end else begin
            esc[0] = r_held;
            k      = 3'd1;
        end
    end

    // length limit: characters beyond the limit are cut, even mid-escape
    always_comb begin
        do_emit   = r_held_v && !r_done;
        sum       = {1'b0, r_count} + {{(CW-2){1'b0}}, k};
        room      = r_count < i_limit;
        rem       = i_limit - r_count;
        m         = (sum > {1'b0, i_limit}) ? rem[2:0] : k;
        res_made  = do_emit && !r_cut && room;
        cut_after = r_cut || (do_emit && (sum >= {1'b0, i_limit}));
        for (int j = 0; j < 4; j++) begin
            ch[j] = (3'(j) < m) ? esc[j] : 8'h00;
        end
    end

    always_comb begin
        n_held      = r_held;
        n_held_v    = r_held_v;
        n_count     = r_count;
        n_cut       = r_cut;
        n_done      = r_done;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out       = r_out;

        if (ev_acc) begin
            n_out.char0          = ch[0];
            n_out.char1          = ch[1];
            n_out.char2          = ch[2];
            n_out.char3          = ch[3];
            n_out.char_count     = m;
            n_out.priority_level = i_ev.level;
            n_out.was_truncated  = cut_after;
            if (!i_ev.finish) begin
                n_out.end_of_message = i_ev.step_final && cut_after;
                if (res_made) begin
                    n_out_valid = 1'b1;
                    n_count     = r_count + {{(CW-3){1'b0}}, m};
                    // cut on the last step: nothing else follows in this message
                    if (i_ev.step_final && cut_after) begin
                        n_done = 1'b1;
                    end
                end
                n_cut    = cut_after;
                n_held   = i_ev.data;
                n_held_v = 1'b1;
            end else begin
                n_out.end_of_message = 1'b1;
                if (!res_made) begin
                    n_out.char0      = '0;
                    n_out.char1      = '0;
                    n_out.char2      = '0;
                    n_out.char3      = '0;
                    n_out.char_count = '0;
                end
                n_out_valid = !r_done;
                n_held_v    = 1'b0;
                n_count     = '0;
                n_cut       = 1'b0;
                n_done      = 1'b0;
            end
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_v    <= 1'b0;
            r_count     <= '0;
            r_cut       <= 1'b0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_held_v    <= n_held_v;
            r_count     <= n_count;
            r_cut       <= n_cut;
            r_done      <= n_done;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_held <= n_held;
        r_out  <= n_out;
    end

    a_done_implies_cut: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_cut)
        else $error("message closed early without truncation");

    a_empty_only_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.char_count == 3'd0) |-> r_out.end_of_message)
        else $error("empty word that does not close a message");

    a_count_in_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= i_limit)
        else $error("output count ran past the limit");

endmodule

FILE: src/syslog_line_header_strip_escape_top.sv
// syslog_line_header_strip_escape_top: top level of the syslog header strip/escape block.
// Depends on slhse_pkg, slhse_chan_if, slhse_header and slhse_escape.
//
// Takes one log message as a stream of byte words (last_byte on the final one) and returns
// one result word per surviving body byte, holding its escaped form in 1 to 4 characters.
// The first 20 bytes of a message (or all of it if shorter) are taken at one word per
// cycle into a header window with no results; a resolve step then parses the
// <N>/<NN>/<-N>/<-> priority and the "Mmm dD HH:MM:SS " timestamp, and the bytes left
// behind the stripped header are replayed from the window at one per cycle while the
// escaper takes them and the input is held off. After that body bytes stream at one word
// per cycle while the escaper takes them. Every byte waits for its successor, since a
// control byte followed by a digit gets the long octal form, so its result leaves one
// word later; the final byte of a message is flushed by an extra close step. Results
// pass through an event register and a result register. The limit in force is the
// smaller of max_output_chars and the line buffer size minus one; characters past it are
// dropped, even in the middle of an escape, and was_truncated is raised. The word that
// closes a message carries end_of_message; a message that ends without a result gets one
// empty word (char_count 0). Configuration writes are always taken (ready is tied high)
// and must only happen while no message is in flight.
module syslog_line_header_strip_escape_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    slhse_chan_if.sink    i_in,
    slhse_chan_if.source  o_out,
    slhse_chan_if.sink    i_cfg
);

    localparam int CW = slhse_pkg::CFG_W;

    // length limit register
    logic [CW-1:0]     r_max_chars;
    logic [CW-1:0]     limit;

    // header stage to escaper
    logic              ev_valid;
    logic              ev_ready;
    slhse_pkg::t_event ev;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_chars <= slhse_pkg::MAX_CHARS_RESET;
        end else if (i_cfg.valid) begin
            r_max_chars <= i_cfg.payload.max_output_chars;
        end
    end

    // clamp to what the line buffer can hold
    assign limit = (r_max_chars < slhse_pkg::LIMIT_CAP) ? r_max_chars : slhse_pkg::LIMIT_CAP;

    slhse_header u_header (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .o_ev_valid (ev_valid),
        .i_ev_ready (ev_ready),
        .o_ev       (ev)
    );

    slhse_escape u_escape (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ev_valid (ev_valid),
        .o_ev_ready (ev_ready),
        .i_ev       (ev),
        .i_limit    (limit),
        .o_out      (o_out)
    );

endmodule
